// ===== rtl/tsl_pkg.sv =====
// package: token record type, codes and character class helpers for the lexer
`timescale 1ns / 1ps
package tsl_pkg;

  localparam int LINE_BITS_DEF   = 24;
  localparam int OFFSET_BITS_DEF = 32;
  localparam logic [5:0] MAX_IDENT_RST = 6'd20;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam int QDEPTH = 4;

  // token kinds
  localparam logic [3:0] K_KEYWORD = 4'd0;
  localparam logic [3:0] K_IDENT   = 4'd1;
  localparam logic [3:0] K_INT     = 4'd2;
  localparam logic [3:0] K_STRING  = 4'd3;
  localparam logic [3:0] K_OPER    = 4'd4;
  localparam logic [3:0] K_SEMI    = 4'd5;
  localparam logic [3:0] K_OPEN    = 4'd6;
  localparam logic [3:0] K_CLOSE   = 4'd7;
  localparam logic [3:0] K_END     = 4'd8;
  localparam logic [3:0] K_ERROR   = 4'd9;

  // operator codes
  localparam logic [2:0] OP_ASSIGN = 3'd0;
  localparam logic [2:0] OP_PLUS   = 3'd1;
  localparam logic [2:0] OP_PLUSEQ = 3'd2;
  localparam logic [2:0] OP_MINUS  = 3'd3;
  localparam logic [2:0] OP_MINEQ  = 3'd4;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_COMMENT  = 3'd1;
  localparam logic [2:0] E_NONASCII = 3'd2;
  localparam logic [2:0] E_IDENT    = 3'd3;
  localparam logic [2:0] E_NUMBER   = 3'd4;
  localparam logic [2:0] E_STRING   = 3'd5;
  localparam logic [2:0] E_OPER     = 3'd6;
  localparam logic [2:0] E_UNKNOWN  = 3'd7;

  // scan modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_NUMBER  = 3'd3;
  localparam logic [2:0] M_STRING  = 3'd4;
  localparam logic [2:0] M_COLON   = 3'd5;
  localparam logic [2:0] M_PLUS    = 3'd6;
  localparam logic [2:0] M_MINUS   = 3'd7;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  kw;
    logic [2:0]  op;
    logic [2:0]  err;
    logic [7:0]  bad;
    logic [23:0] line;
    logic [31:0] off;
    logic [15:0] len;
    logic        last;
  } tok_t;

  localparam logic [7:0] KW_TEXT [6][8] = '{
    '{8'h6E, 8'h75, 8'h6D, 8'h62, 8'h65, 8'h72, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74, 8'h00, 8'h00},
    '{8'h74, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6E, 8'h65, 8'h77, 8'h6C, 8'h69, 8'h6E, 8'h65, 8'h00}
  };
  localparam logic [15:0] KW_LEN [6] = '{16'd6, 16'd6, 16'd5, 16'd5, 16'd3, 16'd7};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  // parallel keyword mask update for the byte at position pos
  function automatic logic [5:0] kw_match(input logic [5:0] cand, input logic [15:0] pos,
                                          input logic [7:0] b);
    logic [5:0] c;
    c = cand;
    for (int i = 0; i < 6; i++) begin
      if ((pos >= KW_LEN[i]) || (KW_TEXT[i][pos[2:0]] != b)) c[i] = 1'b0;
    end
    return c;
  endfunction

endpackage

// ===== rtl/tsl_scan.sv =====
// front end: byte classifier and scanner state, up to two token records per byte
`timescale 1ns / 1ps
module tsl_scan #(
  parameter int LINE_BITS   = tsl_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = tsl_pkg::OFFSET_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [5:0]     cfg_data,
  input  logic           step,
  input  logic [7:0]     text_byte,
  input  logic           end_of_text,
  output logic [1:0]     push_cnt,
  output tsl_pkg::tok_t  rec0,
  output tsl_pkg::tok_t  rec1
);

  logic [5:0]             max_len_r;
  logic [2:0]             mode_r, mode_nxt;
  logic [5:0]             kwc_r, kwc_nxt;
  logic [15:0]            len_r, len_nxt;
  logic [OFFSET_BITS-1:0] soff_r, soff_nxt;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]             nfl_r, nfl_nxt;

  logic          pv, va, vb, used;
  tsl_pkg::tok_t prec, ra, rb;
  logic [2:0]    kw_sel;
  logic          kw_hit;

  function automatic tsl_pkg::tok_t mk(input logic [3:0] kind, input logic [2:0] kw,
                                       input logic [2:0] op, input logic [2:0] err,
                                       input logic [7:0] bad, input logic [LINE_BITS-1:0] ln,
                                       input logic [OFFSET_BITS-1:0] of,
                                       input logic [15:0] len);
    tsl_pkg::tok_t t;
    logic [LINE_BITS+23:0]   lx;
    logic [OFFSET_BITS+31:0] ox;
    lx = {24'd0, ln};
    ox = {32'd0, of};
    t.kind = kind;
    t.kw   = kw;
    t.op   = op;
    t.err  = err;
    t.bad  = bad;
    t.line = lx[23:0];
    t.off  = ox[31:0];
    t.len  = len;
    t.last = 1'b0;
    return t;
  endfunction

  // record for the token still open in the state
  always_comb begin
    pv     = 1'b1;
    kw_sel = 3'd0;
    kw_hit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (kwc_r[i] && (tsl_pkg::KW_LEN[i] == len_r)) begin
        kw_sel = 3'(i);
        kw_hit = 1'b1;
      end
    end
    prec = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_COMMENT, 8'd0, sline_r, soff_r, len_r);
    case (mode_r)
      tsl_pkg::M_COMMENT: ;
      tsl_pkg::M_STRING:
        prec = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_STRING, 8'd0, sline_r, soff_r,
                  len_r);
      tsl_pkg::M_IDENT: begin
        if (len_r > {10'd0, max_len_r})
          prec = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_IDENT, 8'd0, sline_r, soff_r,
                    len_r);
        else if (kw_hit)
          prec = mk(tsl_pkg::K_KEYWORD, kw_sel, 3'd0, tsl_pkg::E_NONE, 8'd0, sline_r, soff_r,
                    len_r);
        else
          prec = mk(tsl_pkg::K_IDENT, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, sline_r, soff_r,
                    len_r);
      end
      tsl_pkg::M_NUMBER: begin
        if (nfl_r[1])
          prec = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_NUMBER, 8'd0, sline_r, soff_r,
                    len_r);
        else
          prec = mk(tsl_pkg::K_INT, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, sline_r, soff_r,
                    len_r);
      end
      tsl_pkg::M_COLON:
        prec = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_OPER, 8'd0, sline_r, soff_r, 16'd1);
      tsl_pkg::M_PLUS:
        prec = mk(tsl_pkg::K_OPER, 3'd0, tsl_pkg::OP_PLUS, tsl_pkg::E_NONE, 8'd0, sline_r,
                  soff_r, 16'd1);
      tsl_pkg::M_MINUS:
        prec = mk(tsl_pkg::K_OPER, 3'd0, tsl_pkg::OP_MINUS, tsl_pkg::E_NONE, 8'd0, sline_r,
                  soff_r, 16'd1);
      default: pv = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    kwc_nxt   = kwc_r;
    len_nxt   = len_r;
    soff_nxt  = soff_r;
    sline_nxt = sline_r;
    line_nxt  = line_r;
    pos_nxt   = pos_r;
    nfl_nxt   = nfl_r;
    va   = 1'b0;
    vb   = 1'b0;
    ra   = prec;
    rb   = prec;
    used = 1'b1;
    if (end_of_text) begin
      va       = pv;
      vb       = 1'b1;
      rb       = mk(tsl_pkg::K_END, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, line_r, pos_r, 16'd0);
      mode_nxt = tsl_pkg::M_IDLE;
    end else begin
      case (mode_r)
        tsl_pkg::M_COMMENT: begin
          if (text_byte == 8'h2A) mode_nxt = tsl_pkg::M_IDLE;
          else begin
            if (text_byte == 8'h0A && line_r != '1) line_nxt = line_r + 1'b1;
            if (len_r != tsl_pkg::LEN_MAX) len_nxt = len_r + 16'd1;
          end
        end
        tsl_pkg::M_STRING: begin
          if (text_byte == 8'h22) begin
            vb       = 1'b1;
            rb       = mk(tsl_pkg::K_STRING, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, sline_r,
                          soff_r, len_r);
            mode_nxt = tsl_pkg::M_IDLE;
          end else begin
            if (text_byte == 8'h0A && line_r != '1) line_nxt = line_r + 1'b1;
            if (!text_byte[7] && len_r != tsl_pkg::LEN_MAX) len_nxt = len_r + 16'd1;
          end
        end
        tsl_pkg::M_IDENT: begin
          if (tsl_pkg::is_alpha(text_byte) || tsl_pkg::is_digit(text_byte) ||
              text_byte == 8'h5F) begin
            kwc_nxt = tsl_pkg::kw_match(kwc_r, len_r, text_byte);
            if (len_r != tsl_pkg::LEN_MAX) len_nxt = len_r + 16'd1;
          end else used = 1'b0;
        end
        tsl_pkg::M_NUMBER: begin
          if (tsl_pkg::is_digit(text_byte)) begin
            if (nfl_r[0]) nfl_nxt = 2'b11;
            if (len_r != tsl_pkg::LEN_MAX) len_nxt = len_r + 16'd1;
          end else used = 1'b0;
        end
        tsl_pkg::M_COLON, tsl_pkg::M_PLUS: begin
          if (text_byte == 8'h3D) begin
            vb       = 1'b1;
            rb       = mk(tsl_pkg::K_OPER, 3'd0,
                          (mode_r == tsl_pkg::M_PLUS) ? tsl_pkg::OP_PLUSEQ : tsl_pkg::OP_ASSIGN,
                          tsl_pkg::E_NONE, 8'd0, sline_r, soff_r, 16'd2);
            mode_nxt = tsl_pkg::M_IDLE;
          end else used = 1'b0;
        end
        tsl_pkg::M_MINUS: begin
          if (text_byte == 8'h3D) begin
            vb       = 1'b1;
            rb       = mk(tsl_pkg::K_OPER, 3'd0, tsl_pkg::OP_MINEQ, tsl_pkg::E_NONE, 8'd0,
                          sline_r, soff_r, 16'd2);
            mode_nxt = tsl_pkg::M_IDLE;
          end else if (tsl_pkg::is_digit(text_byte)) begin
            mode_nxt = tsl_pkg::M_NUMBER;
            len_nxt  = 16'd2;
            nfl_nxt  = {1'b0, text_byte == 8'h30};
          end else used = 1'b0;
        end
        default: used = 1'b0;
      endcase
      if (!used) begin
        // close the pending token, then scan this byte from idle
        va       = pv;
        ra       = prec;
        mode_nxt = tsl_pkg::M_IDLE;
        rb       = mk(tsl_pkg::K_ERROR, 3'd0, 3'd0, tsl_pkg::E_UNKNOWN, text_byte, line_r,
                      pos_r, 16'd1);
        if (text_byte == 8'h0A) begin
          if (line_r != '1) line_nxt = line_r + 1'b1;
        end else if (tsl_pkg::is_space(text_byte)) begin
          vb = 1'b0;
        end else if (text_byte[7]) begin
          vb     = 1'b1;
          rb.err = tsl_pkg::E_NONASCII;
        end else begin
          soff_nxt  = pos_r;
          sline_nxt = line_r;
          len_nxt   = 16'd1;
          if (text_byte == 8'h2A) mode_nxt = tsl_pkg::M_COMMENT;
          else if (tsl_pkg::is_alpha(text_byte)) begin
            mode_nxt = tsl_pkg::M_IDENT;
            kwc_nxt  = tsl_pkg::kw_match(6'h3F, 16'd0, text_byte);
          end else if (tsl_pkg::is_digit(text_byte)) begin
            mode_nxt = tsl_pkg::M_NUMBER;
            nfl_nxt  = {1'b0, text_byte == 8'h30};
          end else begin
            case (text_byte)
              8'h22: begin
                mode_nxt = tsl_pkg::M_STRING;
                len_nxt  = 16'd0;
              end
              8'h3A: mode_nxt = tsl_pkg::M_COLON;
              8'h2B: mode_nxt = tsl_pkg::M_PLUS;
              8'h2D: mode_nxt = tsl_pkg::M_MINUS;
              8'h3B: begin
                vb = 1'b1;
                rb = mk(tsl_pkg::K_SEMI, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, line_r, pos_r,
                        16'd1);
              end
              8'h7B: begin
                vb = 1'b1;
                rb = mk(tsl_pkg::K_OPEN, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, line_r, pos_r,
                        16'd1);
              end
              8'h7D: begin
                vb = 1'b1;
                rb = mk(tsl_pkg::K_CLOSE, 3'd0, 3'd0, tsl_pkg::E_NONE, 8'd0, line_r, pos_r,
                        16'd1);
              end
              default: vb = 1'b1;
            endcase
          end
        end
      end
      if (pos_r != '1) pos_nxt = pos_r + 1'b1;
    end
  end

  // pack the one or two records, marking the final one
  always_comb begin
    rec0     = va ? ra : rb;
    rec1     = rb;
    push_cnt = {1'b0, va} + {1'b0, vb};
    if (va && vb) rec1.last = 1'b1;
    else rec0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= tsl_pkg::MAX_IDENT_RST;
      mode_r    <= tsl_pkg::M_IDLE;
      kwc_r     <= 6'h3F;
      len_r     <= 16'd0;
      soff_r    <= '0;
      sline_r   <= LINE_BITS'(1);
      line_r    <= LINE_BITS'(1);
      pos_r     <= '0;
      nfl_r     <= 2'b00;
    end else begin
      if (cfg_we) max_len_r <= cfg_data;
      if (step) begin
        mode_r  <= mode_nxt;
        kwc_r   <= kwc_nxt;
        len_r   <= len_nxt;
        soff_r  <= soff_nxt;
        sline_r <= sline_nxt;
        line_r  <= line_nxt;
        pos_r   <= pos_nxt;
        nfl_r   <= nfl_nxt;
      end
    end
  end

endmodule

// ===== rtl/tsl_queue.sv =====
// back end: token queue taking up to two records a cycle, draining one per transfer
`timescale 1ns / 1ps
module tsl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push_cnt,
  input  tsl_pkg::tok_t  rec0,
  input  tsl_pkg::tok_t  rec1,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output tsl_pkg::tok_t  head
);

  localparam int AW = $clog2(tsl_pkg::QDEPTH);

  tsl_pkg::tok_t mem_r [tsl_pkg::QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign has_room  = (cnt_r <= (AW + 1)'(tsl_pkg::QDEPTH - 2));
  assign cnt_nxt   = cnt_r + (AW + 1)'(push_cnt) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= rec0;
    if (push_cnt == 2'd2) mem_r[wr_r + 1'b1] <= rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(push_cnt);
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/token_stream_lexer_top.sv =====
// top level: byte lexer, scanner front end feeding a token queue
//
//  channel  direction  payload
//  in_      in         text_byte, end_of_text
//  out_     out        token fields, last
//  cfg_     in         max identifier length (6 bits)
//
// one byte is scanned per cycle while in_ready is high; a byte yields zero, one or two tokens
// the queue drains one token per cycle while out_ready is high; the input stalls only while
// fewer than two queue slots are free (two-token bytes back to back, or a stalled output)
// a byte's tokens enter the queue registers at its transfer, behind any tokens already queued
// reset is synchronous and active low; the scanner returns to idle, line 1, offset 0
`timescale 1ns / 1ps
module token_stream_lexer_top #(
  parameter int LINE_BITS   = tsl_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = tsl_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [2:0]  out_keyword_index,
  output logic [2:0]  out_operator_code,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_bad_byte,
  output logic [23:0] out_start_line,
  output logic [31:0] out_start_offset,
  output logic [15:0] out_lexeme_length,
  output logic        out_last
);

  logic [1:0]    scan_cnt, push_cnt;
  tsl_pkg::tok_t rec0, rec1, head;
  logic          step;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;
  assign push_cnt  = step ? scan_cnt : 2'd0;

  tsl_scan #(.LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .step       (step),
    .text_byte  (in_text_byte),
    .end_of_text(in_end_of_text),
    .push_cnt   (scan_cnt),
    .rec0       (rec0),
    .rec1       (rec1)
  );

  tsl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .rec0     (rec0),
    .rec1     (rec1),
    .has_room (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_token_kind    = head.kind;
  assign out_keyword_index = head.kw;
  assign out_operator_code = head.op;
  assign out_error_code    = head.err;
  assign out_bad_byte      = head.bad;
  assign out_start_line    = head.line;
  assign out_start_offset  = head.off;
  assign out_lexeme_length = head.len;
  assign out_last          = head.last;

endmodule

// ===== rtl/tsl_checker.sv =====
// checker: port-level properties of the lexer, bound to the top level
`timescale 1ns / 1ps
module tsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [2:0]  out_operator_code,
  input logic [2:0]  out_error_code,
  input logic [7:0]  out_bad_byte,
  input logic        out_last
);

  // a stalled token holds its kind
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("token changed while stalled");

  // end token is always the final one of its byte
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == tsl_pkg::K_END |-> out_last)
    else $error("end token without last");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != tsl_pkg::K_ERROR |-> out_error_code == tsl_pkg::E_NONE)
    else $error("error code on non-error token");

  a_op_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != tsl_pkg::K_OPER |-> out_operator_code == 3'd0)
    else $error("operator code on non-operator token");

  a_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != tsl_pkg::E_NONASCII &&
    out_error_code != tsl_pkg::E_UNKNOWN |-> out_bad_byte == 8'd0)
    else $error("bad byte set without a byte error");

endmodule

bind token_stream_lexer_top tsl_checker u_tsl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_operator_code(out_operator_code),
  .out_error_code   (out_error_code),
  .out_bad_byte     (out_bad_byte),
  .out_last         (out_last)
);

// ===== tb/tb.sv =====
// testbench for the token stream lexer: predicts every token and checks each transfer
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [2:0]  out_keyword_index;
  logic [2:0]  out_operator_code;
  logic [2:0]  out_error_code;
  logic [7:0]  out_bad_byte;
  logic [23:0] out_start_line;
  logic [31:0] out_start_offset;
  logic [15:0] out_lexeme_length;
  logic        out_last;

  token_stream_lexer_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_byte(in_text_byte), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_token_kind(out_token_kind), .out_keyword_index(out_keyword_index),
    .out_operator_code(out_operator_code), .out_error_code(out_error_code),
    .out_bad_byte(out_bad_byte), .out_start_line(out_start_line),
    .out_start_offset(out_start_offset), .out_lexeme_length(out_lexeme_length),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  string kw_words [6] = '{"number", "repeat", "times", "write", "and", "newline"};

  // scanner copy
  logic [2:0]  scan_state;
  logic [5:0]  kw_alive;
  logic [15:0] lex_len;
  logic [31:0] lex_off;
  logic [23:0] lex_line;
  logic [23:0] cur_line;
  logic [31:0] cur_pos;
  logic        lead_zero;
  logic        num_bad;
  logic [5:0]  ident_limit;

  tsl_pkg::tok_t tok_expect [$];
  tsl_pkg::tok_t step_toks [$];
  bit   mismatch_seen = 0;
  int   bytes_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || b == 8'd9 || b == 8'd11 || b == 8'd12 || b == 8'd13;
  endfunction

  task automatic add_tok(logic [3:0] kind, logic [2:0] kw, logic [2:0] op, logic [2:0] err,
                         logic [7:0] bad, logic [23:0] line, logic [31:0] off,
                         logic [15:0] len);
    tsl_pkg::tok_t t;
    t = '{kind: kind, kw: kw, op: op, err: err, bad: bad, line: line, off: off,
          len: len, last: 1'b0};
    step_toks.push_back(t);
  endtask

  task automatic bump_line();
    if (cur_line != '1) cur_line++;
  endtask

  task automatic bump_len();
    if (lex_len != tsl_pkg::LEN_MAX) lex_len++;
  endtask

  task automatic open_lexeme(logic [2:0] m, logic [15:0] len);
    scan_state = m;
    lex_len = len;
    lex_off = cur_pos;
    lex_line = cur_line;
  endtask

  task automatic kw_narrow(logic [7:0] b);
    for (int i = 0; i < 6; i++)
      if (lex_len >= kw_words[i].len() || kw_words[i][lex_len] != b) kw_alive[i] = 1'b0;
  endtask

  task automatic close_pending();
    int kw;
    kw = -1;
    case (scan_state)
      tsl_pkg::M_COMMENT:
        add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_COMMENT, '0, lex_line, lex_off, lex_len);
      tsl_pkg::M_STRING:
        add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_STRING, '0, lex_line, lex_off, lex_len);
      tsl_pkg::M_IDENT: begin
        if (lex_len > {10'd0, ident_limit}) begin
          add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_IDENT, '0, lex_line, lex_off, lex_len);
        end else begin
          for (int i = 0; i < 6; i++)
            if (kw_alive[i] && kw_words[i].len() == lex_len) kw = i;
          if (kw >= 0)
            add_tok(tsl_pkg::K_KEYWORD, 3'(kw), '0, tsl_pkg::E_NONE, '0, lex_line, lex_off,
                    lex_len);
          else
            add_tok(tsl_pkg::K_IDENT, '0, '0, tsl_pkg::E_NONE, '0, lex_line, lex_off, lex_len);
        end
      end
      tsl_pkg::M_NUMBER: begin
        if (num_bad)
          add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_NUMBER, '0, lex_line, lex_off, lex_len);
        else
          add_tok(tsl_pkg::K_INT, '0, '0, tsl_pkg::E_NONE, '0, lex_line, lex_off, lex_len);
      end
      tsl_pkg::M_COLON:
        add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_OPER, '0, lex_line, lex_off, 16'd1);
      tsl_pkg::M_PLUS:
        add_tok(tsl_pkg::K_OPER, '0, tsl_pkg::OP_PLUS, tsl_pkg::E_NONE, '0, lex_line, lex_off,
                16'd1);
      tsl_pkg::M_MINUS:
        add_tok(tsl_pkg::K_OPER, '0, tsl_pkg::OP_MINUS, tsl_pkg::E_NONE, '0, lex_line,
                lex_off, 16'd1);
      default: ;
    endcase
    scan_state = tsl_pkg::M_IDLE;
  endtask

  task automatic scan_fresh(logic [7:0] b);
    if (b == "\n") bump_line();
    else if (is_blank(b)) ;
    else if (b > 8'd127)
      add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_NONASCII, b, cur_line, cur_pos, 16'd1);
    else if (b == "*") open_lexeme(tsl_pkg::M_COMMENT, 16'd1);
    else if (is_letter(b)) begin
      open_lexeme(tsl_pkg::M_IDENT, 16'd0);
      kw_alive = '1;
      kw_narrow(b);
      lex_len = 16'd1;
    end else if (is_num(b)) begin
      open_lexeme(tsl_pkg::M_NUMBER, 16'd1);
      lead_zero = (b == "0");
      num_bad = 1'b0;
    end else begin
      case (b)
        "\"": open_lexeme(tsl_pkg::M_STRING, 16'd0);
        ":": open_lexeme(tsl_pkg::M_COLON, 16'd1);
        "+": open_lexeme(tsl_pkg::M_PLUS, 16'd1);
        "-": open_lexeme(tsl_pkg::M_MINUS, 16'd1);
        ";": add_tok(tsl_pkg::K_SEMI, '0, '0, tsl_pkg::E_NONE, '0, cur_line, cur_pos, 16'd1);
        "{": add_tok(tsl_pkg::K_OPEN, '0, '0, tsl_pkg::E_NONE, '0, cur_line, cur_pos, 16'd1);
        "}": add_tok(tsl_pkg::K_CLOSE, '0, '0, tsl_pkg::E_NONE, '0, cur_line, cur_pos, 16'd1);
        default:
          add_tok(tsl_pkg::K_ERROR, '0, '0, tsl_pkg::E_UNKNOWN, b, cur_line, cur_pos, 16'd1);
      endcase
    end
  endtask

  // works out the tokens that one accepted byte gives
  task automatic lex_byte(logic [7:0] b, logic eot);
    bit used;
    used = 1;
    step_toks.delete();
    if (eot) begin
      close_pending();
      add_tok(tsl_pkg::K_END, '0, '0, tsl_pkg::E_NONE, '0, cur_line, cur_pos, 16'd0);
    end else begin
      case (scan_state)
        tsl_pkg::M_COMMENT: begin
          if (b == "*") scan_state = tsl_pkg::M_IDLE;
          else begin
            if (b == "\n") bump_line();
            bump_len();
          end
        end
        tsl_pkg::M_STRING: begin
          if (b == "\"") begin
            add_tok(tsl_pkg::K_STRING, '0, '0, tsl_pkg::E_NONE, '0, lex_line, lex_off,
                    lex_len);
            scan_state = tsl_pkg::M_IDLE;
          end else begin
            if (b == "\n") bump_line();
            if (b <= 8'd127) bump_len();
          end
        end
        tsl_pkg::M_IDENT: begin
          if (is_letter(b) || is_num(b) || b == "_") begin
            kw_narrow(b);
            bump_len();
          end else used = 0;
        end
        tsl_pkg::M_NUMBER: begin
          if (is_num(b)) begin
            if (lead_zero) num_bad = 1'b1;
            bump_len();
          end else used = 0;
        end
        tsl_pkg::M_COLON, tsl_pkg::M_PLUS: begin
          if (b == "=") begin
            add_tok(tsl_pkg::K_OPER, '0,
                    scan_state == tsl_pkg::M_COLON ? tsl_pkg::OP_ASSIGN : tsl_pkg::OP_PLUSEQ,
                    tsl_pkg::E_NONE, '0, lex_line, lex_off, 16'd2);
            scan_state = tsl_pkg::M_IDLE;
          end else used = 0;
        end
        tsl_pkg::M_MINUS: begin
          if (b == "=") begin
            add_tok(tsl_pkg::K_OPER, '0, tsl_pkg::OP_MINEQ, tsl_pkg::E_NONE, '0, lex_line,
                    lex_off, 16'd2);
            scan_state = tsl_pkg::M_IDLE;
          end else if (is_num(b)) begin
            // sign joins the number
            scan_state = tsl_pkg::M_NUMBER;
            lex_len = 16'd2;
            lead_zero = (b == "0");
            num_bad = 1'b0;
          end else used = 0;
        end
        default: used = 0;
      endcase
      if (!used) begin
        close_pending();
        scan_fresh(b);
      end
      if (cur_pos != '1) cur_pos++;
    end
    if (step_toks.size() > 0) step_toks[$].last = 1'b1;
    foreach (step_toks[i]) tok_expect.push_back(step_toks[i]);
  endtask

  task automatic send_byte(logic [7:0] b, logic eot);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = b;
    in_end_of_text = eot;
    do @(posedge clk); while (!in_ready);
    lex_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic set_ident_limit(logic [5:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (tok_expect.size() != 0) @(negedge clk);
    // all expected tokens have left, leave some margin
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    ident_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      mismatch_seen = 1;
    end
  endfunction

  always @(posedge clk) begin
    tsl_pkg::tok_t e;
    if (rst_n && out_valid && out_ready) begin
      if (tok_expect.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d", $time,
                 out_token_kind);
        mismatch_seen = 1;
      end else begin
        e = tok_expect.pop_front();
        check_field("token_kind", 32'(e.kind), 32'(out_token_kind));
        check_field("keyword_index", 32'(e.kw), 32'(out_keyword_index));
        check_field("operator_code", 32'(e.op), 32'(out_operator_code));
        check_field("error_code", 32'(e.err), 32'(out_error_code));
        check_field("bad_byte", 32'(e.bad), 32'(out_bad_byte));
        check_field("start_line", 32'(e.line), 32'(out_start_line));
        check_field("start_offset", e.off, out_start_offset);
        check_field("lexeme_length", 32'(e.len), 32'(out_lexeme_length));
        check_field("last", 32'(e.last), 32'(out_last));
      end
    end
  end

  always @(negedge clk) out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_text(":=+=-=+-9;{}");
    send_byte(8'hFF, 1'b0);
    send_text("@:\n07 x_1 and");
    send_byte(8'h00, 1'b1);
    send_text("\"a\nb");
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("*q");
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic send_random_token();
    int n;
    logic [7:0] b;
    case ($urandom_range(10))
      0: send_text(kw_words[$urandom_range(5)]);
      1: begin
        n = ($urandom_range(3) == 0) ? int'(ident_limit) + int'($urandom_range(2))
                                     : int'($urandom_range(1, 8));
        if (n == 0) n = 1;
        send_byte($urandom_range(1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z")), 1'b0);
        for (int i = 1; i < n; i++) begin
          case ($urandom_range(3))
            0: b = 8'($urandom_range("0", "9"));
            1: b = "_";
            default: b = 8'($urandom_range("a", "z"));
          endcase
          send_byte(b, 1'b0);
        end
      end
      2: begin
        if ($urandom_range(2) == 0) send_byte("-", 1'b0);
        if ($urandom_range(2) == 0) send_byte("0", 1'b0);
        else send_byte(8'($urandom_range("1", "9")), 1'b0);
        repeat ($urandom_range(4)) send_byte(8'($urandom_range("0", "9")), 1'b0);
      end
      3: begin
        send_byte("\"", 1'b0);
        repeat ($urandom_range(6)) begin
          case ($urandom_range(3))
            0: b = 8'($urandom_range(128, 255));
            1: b = "\n";
            default: b = 8'($urandom_range(" ", "~"));
          endcase
          if (b == "\"") b = "a";
          send_byte(b, 1'b0);
        end
        if ($urandom_range(9) != 0) send_byte("\"", 1'b0);
      end
      4: begin
        send_byte("*", 1'b0);
        repeat ($urandom_range(5)) begin
          b = 8'($urandom_range(255));
          if (b == "*") b = "\n";
          send_byte(b, 1'b0);
        end
        send_byte("*", 1'b0);
      end
      5: begin
        case ($urandom_range(5))
          0: send_text(":=");
          1: send_text("+");
          2: send_text("+=");
          3: send_text("-");
          4: send_text("-=");
          default: send_text(":");
        endcase
      end
      6: begin
        case ($urandom_range(2))
          0: send_byte(";", 1'b0);
          1: send_byte("{", 1'b0);
          default: send_byte("}", 1'b0);
        endcase
      end
      7: begin
        case ($urandom_range(5))
          0: send_byte(8'd9, 1'b0);
          1: send_byte(8'd11, 1'b0);
          2: send_byte(8'd12, 1'b0);
          3: send_byte(8'd13, 1'b0);
          4: send_byte(" ", 1'b0);
          default: send_byte("\n", 1'b0);
        endcase
      end
      8: send_byte(8'($urandom_range(255)), 1'b0);
      9: if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)), 1'b1);
      default: ;
    endcase
    if ($urandom_range(1)) send_byte(" ", 1'b0);
  endtask

  task automatic test_random(int idle, int stall, int count);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_token();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    scan_state = tsl_pkg::M_IDLE;
    kw_alive = '1;
    lex_len = '0;
    lex_off = '0;
    lex_line = 24'd1;
    cur_line = 24'd1;
    cur_pos = '0;
    lead_zero = 1'b0;
    num_bad = 1'b0;
    ident_limit = tsl_pkg::MAX_IDENT_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    set_ident_limit(6'd63);
    test_random(0, 0, 175);
    set_ident_limit(6'd1);
    test_random(53, 0, 175);
    set_ident_limit(6'd0);
    test_random(0, 53, 175);
    set_ident_limit(6'd7);
    test_random(31, 31, 175);

    @(negedge clk);
    in_valid = 1'b0;
    while (tok_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_seen) $display("*** FAILED ***");
    else $display("*** PASSED ***");
    $finish;
  end

endmodule
